>>> hw/rtl/bdr_pkg.sv
// Shared types, constants and helpers for the box downscaler.
package bdr_pkg;

   localparam int DefMaxWidth  = 2048;
   localparam int DefMaxHeight = 2048;
   localparam int Channels     = 4;
   localparam int RegWidth     = 12;
   localparam int SumWidth     = 30;
   localparam int PixWidth     = 8;
   localparam int CsrIdxWidth  = 2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_TARGET_WIDTH  = 2'd2,
      CSR_TARGET_HEIGHT = 2'd3
   } csr_index_type;

   typedef logic [PixWidth-1:0] pix_type;
   typedef pix_type [Channels-1:0] pixel_type;
   typedef logic [SumWidth-1:0] sum_type;

   // Classified work for the back end: one entry per source pixel
   typedef struct packed {
      pixel_type  pix;
      logic       in_frame;      // pixel falls inside a kept box
      logic       row_end;       // last pixel of the source row
      logic       box_col_end;   // last column of horizontal box
      logic       first_row;     // first row of the band
      logic       last_row;      // last row of the band
      logic       last_out;      // final output pixel of the frame
      logic [13:0] out_col;      // output column index
   } work_type;

   // Zero acts as one, larger than hi acts as hi
   function automatic logic [13:0] clamp_size(input logic [13:0] v, input logic [13:0] hi);
      logic [13:0] r;
      if (v == 14'd0) r = 14'd1;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

>>> hw/rtl/bdr_if.sv
// Valid/ready channel interfaces for pixel, result and register traffic.
interface bdr_req_if;
   import bdr_pkg::*;
   logic valid;
   logic ready;
   pix_type red_in, green_in, blue_in, alpha_in;
   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface bdr_rsp_if;
   import bdr_pkg::*;
   logic valid;
   logic ready;
   pix_type red_out, green_out, blue_out, alpha_out;
   logic frame_done;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_done,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, frame_done,
                 output ready);
endinterface

interface bdr_csr_if;
   import bdr_pkg::*;
   logic valid;
   logic ready;
   logic [CsrIdxWidth-1:0] index;
   logic [RegWidth-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bdr_divider.sv
// Iterative restoring divider: sum / area, one quotient bit per cycle.
module bdr_divider
   import bdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  sum_type     dividend,
   input  logic [23:0] divisor,
   output logic        busy,
   output logic        done,
   output pix_type     quotient
);
   logic [4:0]  count_ff, count_in;
   sum_type     quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] div_ff, div_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [24:0] trial;

   // one restoring step per cycle
   always_comb begin
      count_in = count_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[23:0], quo_ff[SumWidth-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         count_in = 5'(SumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[SumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumWidth-2:0], 1'b0};
         end
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = quo_ff[PixWidth-1:0];
endmodule

>>> hw/rtl/bdr_front.sv
// Front end: tracks raster position and classifies each source pixel.
module bdr_front
   import bdr_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight
)(
   input  logic        clock,
   input  logic        reset,
   bdr_req_if.sink     req,
   bdr_csr_if.sink     csr,
   input  logic        q_full,
   output logic        q_push,
   output work_type    q_data,
   output logic [23:0] area
);
   logic [RegWidth-1:0] sw_reg_ff, sh_reg_ff, tw_reg_ff, th_reg_ff;
   logic [13:0] sw, sh, tw, th;
   logic [13:0] div_w_ff, div_h_ff, tw_ff, th_ff, sw_ff, sh_ff;
   logic [11:0] area_w_ff, area_h_ff;
   logic [13:0] src_col_ff, src_row_ff, box_col_ff, box_row_ff, out_col_ff, out_row_ff;
   logic [13:0] src_col_in, src_row_in, box_col_in, box_row_in, out_col_in, out_row_in;
   logic [3:0]  dcnt_ff;
   logic [13:0] qw_ff, qh_ff, rw_ff, rh_ff;
   logic        cfg_busy_ff, cfg_load_ff, cfg_wait_ff;
   logic        take, in_frame, col_end;

   // register writes; sizes are recomputed after each write
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_reg_ff <= 12'd1;
         sh_reg_ff <= 12'd1;
         tw_reg_ff <= 12'd1;
         th_reg_ff <= 12'd1;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_SOURCE_WIDTH:  sw_reg_ff <= csr.data;
            CSR_SOURCE_HEIGHT: sh_reg_ff <= csr.data;
            CSR_TARGET_WIDTH:  tw_reg_ff <= csr.data;
            CSR_TARGET_HEIGHT: th_reg_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign sw = clamp_size({2'b0, sw_reg_ff}, 14'(MAX_WIDTH));
   assign sh = clamp_size({2'b0, sh_reg_ff}, 14'(MAX_HEIGHT));
   assign tw = clamp_size({2'b0, tw_reg_ff}, sw);
   assign th = clamp_size({2'b0, th_reg_ff}, sh);

   // division starts the cycle after a write, once the new sizes are visible;
   // the input is also held by cfg_wait_ff while the factor registers settle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_load_ff <= 1'b0;
         cfg_wait_ff <= 1'b0;
      end else begin
         cfg_load_ff <= csr.valid && csr.ready;
         cfg_wait_ff <= cfg_busy_ff;
      end
   end

   // box factors by 14-step serial restoring division, started on reset and each write
   always_ff @(posedge clock) begin
      if (reset || cfg_load_ff) begin
         cfg_busy_ff <= 1'b1;
         dcnt_ff <= 4'd14;
         qw_ff <= sw;
         qh_ff <= sh;
         rw_ff <= '0;
         rh_ff <= '0;
      end else if (cfg_busy_ff) begin
         if ({rw_ff[12:0], qw_ff[13]} >= tw) begin
            rw_ff <= {rw_ff[12:0], qw_ff[13]} - tw;
            qw_ff <= {qw_ff[12:0], 1'b1};
         end else begin
            rw_ff <= {rw_ff[12:0], qw_ff[13]};
            qw_ff <= {qw_ff[12:0], 1'b0};
         end
         if ({rh_ff[12:0], qh_ff[13]} >= th) begin
            rh_ff <= {rh_ff[12:0], qh_ff[13]} - th;
            qh_ff <= {qh_ff[12:0], 1'b1};
         end else begin
            rh_ff <= {rh_ff[12:0], qh_ff[13]};
            qh_ff <= {qh_ff[12:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 4'd1;
         if (dcnt_ff == 4'd1) cfg_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sw_ff <= sw;
      sh_ff <= sh;
      tw_ff <= tw;
      th_ff <= th;
      div_w_ff <= qw_ff;
      div_h_ff <= qh_ff;
      area_w_ff <= qw_ff[11:0];
      area_h_ff <= qh_ff[11:0];
   end
   assign area = area_w_ff * area_h_ff;

   assign req.ready = !q_full && !cfg_load_ff && !cfg_busy_ff && !cfg_wait_ff;
   assign take = req.valid && req.ready;
   assign in_frame = (out_col_ff < tw_ff) && (out_row_ff < th_ff);
   assign col_end = box_col_ff >= div_w_ff - 14'd1;

   // raster and box counters
   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      box_col_in = box_col_ff;
      box_row_in = box_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (in_frame) begin
         if (col_end) begin
            out_col_in = out_col_ff + 14'd1;
            box_col_in = '0;
         end else begin
            box_col_in = box_col_ff + 14'd1;
         end
      end
      if (src_col_ff >= sw_ff - 14'd1) begin
         src_col_in = '0;
         box_col_in = '0;
         out_col_in = '0;
         if (out_row_ff < th_ff) begin
            if (box_row_ff >= div_h_ff - 14'd1) begin
               box_row_in = '0;
               out_row_in = out_row_ff + 14'd1;
            end else begin
               box_row_in = box_row_ff + 14'd1;
            end
         end
         if (src_row_ff >= sh_ff - 14'd1) begin
            src_row_in = '0;
            out_row_in = '0;
            box_row_in = '0;
         end else begin
            src_row_in = src_row_ff + 14'd1;
         end
      end else begin
         src_col_in = src_col_ff + 14'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         box_col_ff <= '0;
         box_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (take) begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         box_col_ff <= box_col_in;
         box_row_ff <= box_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // classified item toward the queue; dropped pixels still mark row ends
   assign q_push = take;
   always_comb begin
      q_data.pix = {req.alpha_in, req.blue_in, req.green_in, req.red_in};
      q_data.in_frame = in_frame;
      q_data.row_end = src_col_ff >= sw_ff - 14'd1;
      q_data.box_col_end = in_frame && col_end;
      q_data.first_row = box_row_ff == 14'd0;
      q_data.last_row = box_row_ff >= div_h_ff - 14'd1;
      q_data.last_out = (out_col_ff == tw_ff - 14'd1) && (out_row_ff == th_ff - 14'd1);
      q_data.out_col = out_col_ff;
   end
endmodule

>>> hw/rtl/bdr_queue.sv
// Small FIFO between front and back ends.
module bdr_queue
   import bdr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type pop_data
);
   work_type    mem_ff [4];
   logic [1:0]  wr_ff, rd_ff;
   logic [2:0]  cnt_ff;

   assign full = cnt_ff == 3'd4;
   assign empty = cnt_ff == 3'd0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

>>> hw/rtl/bdr_back.sv
// Back end: row and column accumulation, line store, box mean division.
module bdr_back
   import bdr_pkg::*;
#(
   parameter int MAX_WIDTH = DefMaxWidth
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  work_type    q_data,
   output logic        q_pop,
   input  logic [23:0] area,
   bdr_rsp_if.source   rsp
);
   localparam int ColBits = $clog2(MAX_WIDTH);

   typedef enum logic [1:0] {ST_TAKE, ST_READ, ST_DIV, ST_OUT} state_type;

   state_type  state_ff;
   sum_type    run_ff [Channels];
   sum_type    line_mem [MAX_WIDTH * Channels];
   sum_type    rd_data_ff;
   sum_type    box_ff [Channels];
   pix_type    mean_ff [Channels];
   work_type   item_ff;
   logic [1:0] ch_ff;
   logic       rsp_valid_ff, frame_done_ff;
   logic       div_start, div_busy, div_done;
   pix_type    div_q;
   sum_type    add_sum;
   logic [ColBits+1:0] addr;

   bdr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(box_ff[ch_ff]),
      .divisor(area), .busy(div_busy), .done(div_done), .quotient(div_q)
   );

   assign addr = {item_ff.out_col[ColBits-1:0], ch_ff};
   assign q_pop = (state_ff == ST_TAKE) && !q_empty && !rsp_valid_ff;
   assign add_sum = item_ff.first_row ? run_ff[ch_ff] : rd_data_ff + run_ff[ch_ff];
   // one division per channel, started as soon as the divider is idle
   assign div_start = (state_ff == ST_DIV) && !div_busy && !div_done;

   // line store read port
   always_ff @(posedge clock) begin
      rd_data_ff <= line_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         ch_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < Channels; c++) run_ff[c] <= '0;
      end else begin
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_TAKE: begin
               if (q_pop) begin
                  item_ff <= q_data;
                  ch_ff <= '0;
                  if (q_data.box_col_end) begin
                     for (int c = 0; c < Channels; c++)
                        run_ff[c] <= run_ff[c] + SumWidth'(q_data.pix[c]);
                     state_ff <= ST_READ;
                  end else if (q_data.row_end) begin
                     // row ends inside a box or in the dropped region
                     for (int c = 0; c < Channels; c++) run_ff[c] <= '0;
                  end else if (q_data.in_frame) begin
                     for (int c = 0; c < Channels; c++)
                        run_ff[c] <= run_ff[c] + SumWidth'(q_data.pix[c]);
                  end
               end
            end
            // one channel at a time: ST_READ waits for the line store read, then ST_OUT accumulates and writes
            ST_READ: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               line_mem[addr] <= add_sum;
               box_ff[ch_ff] <= add_sum;
               run_ff[ch_ff] <= '0;
               if (ch_ff == 2'(Channels - 1)) begin
                  ch_ff <= '0;
                  state_ff <= item_ff.last_row ? ST_DIV : ST_TAKE;
               end else begin
                  ch_ff <= ch_ff + 2'd1;
                  state_ff <= ST_READ;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  mean_ff[ch_ff] <= div_q;
                  if (ch_ff == 2'(Channels - 1)) begin
                     ch_ff <= '0;
                     rsp_valid_ff <= 1'b1;
                     frame_done_ff <= item_ff.last_out;
                     state_ff <= ST_TAKE;
                  end else begin
                     ch_ff <= ch_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= ST_TAKE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.red_out = mean_ff[0];
   assign rsp.green_out = mean_ff[1];
   assign rsp.blue_out = mean_ff[2];
   assign rsp.alpha_out = mean_ff[3];
   assign rsp.frame_done = frame_done_ff;
endmodule

>>> hw/rtl/box_downscale_rgba_core.sv
// An in-box pixel only adds to the running sums; a box-closing pixel also updates
// the line store channel by channel and, on the band's last row, runs each channel
// through the shared serial divider. Throughput: 1 pixel per cycle outside box ends
// when the queue has room. A register write stalls the input during factor division.
// Synchronous active-high reset clears counters, the queue and size registers (1);
// the line store is not cleared: each band's first row writes it.
module box_downscale_rgba_core
   import bdr_pkg::*;
#(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight
)(
   input  logic     clock,
   input  logic     reset,
   bdr_req_if.sink  req,
   bdr_rsp_if.source rsp,
   bdr_csr_if.sink  csr
);
   logic        q_push, q_full, q_pop, q_empty;
   work_type    q_in, q_out;
   logic [23:0] area;

   bdr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset), .req(req), .csr(csr), .q_full(q_full),
      .q_push(q_push), .q_data(q_in), .area(area)
   );

   bdr_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out)
   );

   bdr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
      .area(area), .rsp(rsp)
   );
endmodule

>>> hw/rtl/bdr_checker.sv
// Port-level checker for the box downscaler, bound to the top level.
module bdr_port_checks (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_frame_done,
   input logic req_ready,
   input logic csr_valid
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");
   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> !req_ready) else $error("input taken during factor update");
   a_done_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_frame_done)) else $error("frame flag unknown");
endmodule

bind box_downscale_rgba_core bdr_port_checks u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_frame_done(rsp.frame_done), .req_ready(req.ready), .csr_valid(csr.valid)
);

>>> verif/bdr_checker.sv
// Scoreboard for the box downscaler: predicts output pixels and compares them.
`timescale 1ns / 1ps
module bdr_checker
   import bdr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bdr_req_if   req,
   bdr_rsp_if   rsp,
   bdr_csr_if   csr,
   output int   fail_count,
   output int   pending,
   output int   rsp_seen
);

   typedef struct {
      pixel_type pix;
      logic      done;
   } box_mean_type;

   // Register shadow and predictor state
   logic [RegWidth-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
   sum_type             line_sums[DefMaxWidth*Channels];
   sum_type             run_sums[Channels];
   int                  src_col, src_row, box_col, box_row, out_col, out_row;
   box_mean_type        means_q[$];

   function automatic int eff_size(logic [RegWidth-1:0] v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
   endfunction

   task automatic report(string what, int want, int got);
      $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $realtime);
      fail_count++;
   endtask

   // Advance the downscaler by one source pixel, queue any finished box mean
   function automatic void step_pixel(pixel_type px);
      int           sw, sh, tw, th, dw, dh, idx;
      sum_type      s;
      logic         last_row;
      box_mean_type m;
      sw = eff_size(src_w_reg, DefMaxWidth);
      sh = eff_size(src_h_reg, DefMaxHeight);
      tw = eff_size(tgt_w_reg, sw);
      th = eff_size(tgt_h_reg, sh);
      dw = sw / tw;
      dh = sh / th;
      if (out_col < tw && out_row < th) begin
         for (int c = 0; c < Channels; c++) run_sums[c] = run_sums[c] + sum_type'(px[c]);
         if (box_col >= dw - 1) begin
            last_row = (box_row >= dh - 1);
            for (int c = 0; c < Channels; c++) begin
               idx = out_col * Channels + c;
               s = (box_row == 0) ? run_sums[c] : line_sums[idx] + run_sums[c];
               line_sums[idx] = s;
               run_sums[c] = '0;
               m.pix[c] = pix_type'(s / sum_type'(dw * dh));
            end
            if (last_row) begin
               m.done = (out_col == tw - 1 && out_row == th - 1);
               means_q.push_back(m);
            end
            out_col++;
            box_col = 0;
         end else begin
            box_col++;
         end
      end
      // End of source row and frame
      if (src_col >= sw - 1) begin
         src_col = 0;
         box_col = 0;
         out_col = 0;
         for (int c = 0; c < Channels; c++) run_sums[c] = '0;
         if (out_row < th) begin
            if (box_row >= dh - 1) begin
               box_row = 0;
               out_row++;
            end else begin
               box_row++;
            end
         end
         if (src_row >= sh - 1) begin
            src_row = 0;
            out_row = 0;
            box_row = 0;
         end else begin
            src_row++;
         end
      end else begin
         src_col++;
      end
   endfunction

   assign pending = means_q.size();

   always @(posedge clock) begin
      box_mean_type m;
      pixel_type    got;
      if (reset) begin
         src_w_reg <= 1; src_h_reg <= 1; tgt_w_reg <= 1; tgt_h_reg <= 1;
         src_col = 0; src_row = 0; box_col = 0; box_row = 0; out_col = 0; out_row = 0;
         for (int c = 0; c < Channels; c++) run_sums[c] = '0;
         means_q.delete();
      end else begin
         // Register transfer
         if (csr.valid && csr.ready) begin
            case (csr_index_type'(csr.index))
               CSR_SOURCE_WIDTH:  src_w_reg <= csr.data;
               CSR_SOURCE_HEIGHT: src_h_reg <= csr.data;
               CSR_TARGET_WIDTH:  tgt_w_reg <= csr.data;
               CSR_TARGET_HEIGHT: tgt_h_reg <= csr.data;
               default: ;
            endcase
         end
         // Result transfer, checked against oldest prediction
         if (rsp.valid && rsp.ready) begin
            rsp_seen++;
            got = {rsp.alpha_out, rsp.blue_out, rsp.green_out, rsp.red_out};
            if (means_q.size() == 0) begin
               report("unexpected pixel, red", -1, rsp.red_out);
            end else begin
               m = means_q.pop_front();
               if (got[0] !== m.pix[0]) report("red_out", m.pix[0], got[0]);
               if (got[1] !== m.pix[1]) report("green_out", m.pix[1], got[1]);
               if (got[2] !== m.pix[2]) report("blue_out", m.pix[2], got[2]);
               if (got[3] !== m.pix[3]) report("alpha_out", m.pix[3], got[3]);
               if (rsp.frame_done !== m.done) report("frame_done", m.done, rsp.frame_done);
            end
         end
         // Source pixel transfer
         if (req.valid && req.ready)
            step_pixel({req.alpha_in, req.blue_in, req.green_in, req.red_in});
      end
   end

   initial begin
      fail_count = 0;
      rsp_seen = 0;
   end

endmodule

>>> verif/testbench.sv
// Top of the box downscaler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
   import bdr_pkg::*;

   localparam int DrainCycles = 400;
   localparam int StallLimit  = 20000;

   logic clock;
   logic reset;
   int   fail_count, pending, rsp_seen;
   int   idle_cycles;
   logic quiet;

   bdr_req_if req ();
   bdr_rsp_if rsp ();
   bdr_csr_if csr ();

   box_downscale_rgba_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   bdr_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .fail_count (fail_count),
      .pending    (pending),
      .rsp_seen   (rsp_seen)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int eff_size(logic [RegWidth-1:0] v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
   endfunction

   // Random gap length: mostly short, a few long, none in quiet stretches
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [RegWidth-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   // Wait until every predicted pixel has come out and the back end is quiet
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // One whole frame; fill < 0 gives random pixels, else every channel = fill
   task automatic run_frame(logic [RegWidth-1:0] sw, logic [RegWidth-1:0] sh,
                            logic [RegWidth-1:0] tw, logic [RegWidth-1:0] th,
                            int fill, inout int sent);
      int count, g;
      write_reg(CSR_SOURCE_WIDTH, sw);
      write_reg(CSR_SOURCE_HEIGHT, sh);
      write_reg(CSR_TARGET_WIDTH, tw);
      write_reg(CSR_TARGET_HEIGHT, th);
      count = eff_size(sw, DefMaxWidth) * eff_size(sh, DefMaxHeight);
      for (int i = 0; i < count; i++) begin
         req.valid    <= 1'b1;
         req.red_in   <= (fill < 0) ? pix_type'($urandom) : pix_type'(fill);
         req.green_in <= (fill < 0) ? pix_type'($urandom) : pix_type'(fill);
         req.blue_in  <= (fill < 0) ? pix_type'($urandom) : pix_type'(fill);
         req.alpha_in <= (fill < 0) ? pix_type'($urandom) : pix_type'(fill);
         do @(posedge clock); while (!req.ready);
         g = gap_len();
         if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      req.valid <= 1'b0;
      sent += count;
      drain();
   endtask

   // Result side back-pressure, with one long hold once results flow
   initial begin
      logic held;
      int   r;
      held = 1'b0;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (!held && rsp_seen >= 40) begin
            held = 1'b1;
            rsp.ready <= 1'b0;
            repeat (600) @(posedge clock);
         end else if (quiet || r < 75) begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end else if (r < 97) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   // Alternate stretches with and without idling
   initial begin
      quiet = 1'b0;
      forever begin
         repeat ($urandom_range(300, 900)) @(posedge clock);
         quiet = !quiet;
      end
   end

   // Watchdog: too long without any transfer
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      int sent, sw, sh;
      sent = 0;
      idle_cycles = 0;
      req.valid <= 1'b0;
      req.red_in <= '0; req.green_in <= '0; req.blue_in <= '0; req.alpha_in <= '0;
      csr.valid <= 1'b0;
      csr.index <= CSR_SOURCE_WIDTH;
      csr.data  <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extreme pixels, zero registers, dropped edges, clamping
      run_frame(1, 1, 1, 1, 255, sent);
      run_frame(0, 0, 0, 0, 0, sent);
      run_frame(4, 4, 2, 2, 255, sent);
      run_frame(5, 3, 2, 1, -1, sent);
      run_frame(3, 2, 7, 9, -1, sent);
      // Oversize source width acts as the maximum
      run_frame(12'hFFF, 1, 12'h400, 12'hFFF, -1, sent);

      // Random frames, mostly small, on top of the directed ones
      while (sent < 2200) begin
         if ($urandom_range(0, 9) == 0) begin
            sw = $urandom_range(16, 64);
            sh = $urandom_range(1, 3);
         end else begin
            sw = $urandom_range(0, 12);
            sh = $urandom_range(0, 8);
         end
         run_frame(RegWidth'(sw), RegWidth'(sh), RegWidth'($urandom_range(0, sw + 2)),
                   RegWidth'($urandom_range(0, sh + 2)), -1, sent);
      end

      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
